>>> hdl/assert_macros.svh
// Assertion macros for the scrolling text renderer RTL; included by stwr_ctrl.
// Each macro expects clk and rst_n in scope of the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/stwr_pkg.sv
// Package for the scrolling text renderer: widths, codes, font ROM and helpers.
// No dependencies; imported by the controller, the rasterizer and the top level.
package stwr_pkg;

  localparam int DEF_MAX_CHARS = 64;
  localparam int PANEL_ROWS    = 8;
  localparam int PANEL_WIDTH   = 32;
  localparam int GLYPH_WIDTH   = 6;
  localparam int FONT_ROWS     = 7;
  localparam int GLYPH_CODE_W  = 5;
  localparam int ROW_W         = 3;
  localparam int LEN_W         = 7;
  localparam int POS_W         = 10;

  // A frame touches at most seven glyphs: offset up to five plus 32 columns.
  localparam int NUM_SLOTS = 7;
  localparam int STRIP_W   = NUM_SLOTS * GLYPH_WIDTH;
  localparam int OFF_W     = 3;
  localparam int SLOT_W    = 3;

  // The scroll position is biased by six glyphs so that the division is unsigned.
  localparam int BIAS_SLOTS = 6;
  localparam int BIAS_COLS  = BIAS_SLOTS * GLYPH_WIDTH;

  // Division by six as a multiply by 683 / 4096, exact for values below 548.
  localparam int RECIP6       = 683;
  localparam int RECIP6_SHIFT = 12;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(PANEL_ROWS - 1);

  localparam logic [GLYPH_CODE_W-1:0] GLYPH_BLANK = 5'd0;
  localparam logic [GLYPH_CODE_W-1:0] GLYPH_BANG  = 5'd27;

  localparam logic [7:0] ASCII_A    = 8'h41;
  localparam logic [7:0] ASCII_Z    = 8'h5A;
  localparam logic [7:0] ASCII_BANG = 8'h21;

  // Bit 5 of each entry is the leftmost pixel column of the glyph.
  localparam logic [GLYPH_WIDTH-1:0] FONT_ROM [0:31][0:FONT_ROWS-1] = '{
    '{6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00},
    '{6'h08, 6'h14, 6'h22, 6'h3E, 6'h22, 6'h22, 6'h22},
    '{6'h3C, 6'h22, 6'h22, 6'h3C, 6'h22, 6'h22, 6'h3C},
    '{6'h1C, 6'h22, 6'h20, 6'h20, 6'h20, 6'h22, 6'h1C},
    '{6'h3C, 6'h22, 6'h22, 6'h22, 6'h22, 6'h22, 6'h3C},
    '{6'h3E, 6'h20, 6'h20, 6'h3C, 6'h20, 6'h20, 6'h3E},
    '{6'h3E, 6'h20, 6'h20, 6'h3C, 6'h20, 6'h20, 6'h20},
    '{6'h1C, 6'h22, 6'h20, 6'h26, 6'h22, 6'h22, 6'h1E},
    '{6'h22, 6'h22, 6'h22, 6'h3E, 6'h22, 6'h22, 6'h22},
    '{6'h1C, 6'h08, 6'h08, 6'h08, 6'h08, 6'h08, 6'h1C},
    '{6'h0E, 6'h04, 6'h04, 6'h04, 6'h04, 6'h24, 6'h18},
    '{6'h22, 6'h24, 6'h28, 6'h30, 6'h28, 6'h24, 6'h22},
    '{6'h20, 6'h20, 6'h20, 6'h20, 6'h20, 6'h20, 6'h3E},
    '{6'h22, 6'h36, 6'h2A, 6'h22, 6'h22, 6'h22, 6'h22},
    '{6'h22, 6'h32, 6'h2A, 6'h26, 6'h22, 6'h22, 6'h22},
    '{6'h1C, 6'h22, 6'h22, 6'h22, 6'h22, 6'h22, 6'h1C},
    '{6'h3C, 6'h22, 6'h22, 6'h3C, 6'h20, 6'h20, 6'h20},
    '{6'h1C, 6'h22, 6'h22, 6'h22, 6'h2A, 6'h24, 6'h1A},
    '{6'h3C, 6'h22, 6'h22, 6'h3C, 6'h28, 6'h24, 6'h22},
    '{6'h1C, 6'h22, 6'h20, 6'h1C, 6'h02, 6'h22, 6'h1C},
    '{6'h3E, 6'h08, 6'h08, 6'h08, 6'h08, 6'h08, 6'h08},
    '{6'h22, 6'h22, 6'h22, 6'h22, 6'h22, 6'h22, 6'h1C},
    '{6'h22, 6'h22, 6'h22, 6'h22, 6'h22, 6'h14, 6'h08},
    '{6'h22, 6'h22, 6'h22, 6'h22, 6'h2A, 6'h2A, 6'h14},
    '{6'h22, 6'h22, 6'h14, 6'h08, 6'h14, 6'h22, 6'h22},
    '{6'h22, 6'h22, 6'h22, 6'h14, 6'h08, 6'h08, 6'h08},
    '{6'h3E, 6'h02, 6'h04, 6'h08, 6'h10, 6'h20, 6'h3E},
    '{6'h08, 6'h08, 6'h08, 6'h08, 6'h08, 6'h00, 6'h08},
    '{6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00},
    '{6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00},
    '{6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00},
    '{6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00}
  };

  // Glyphs fetched for one frame plus where the panel starts inside them and the row to draw.
  typedef struct packed {
    logic [NUM_SLOTS-1:0][GLYPH_CODE_W-1:0] codes;
    logic [OFF_W-1:0]                       offset;
    logic [ROW_W-1:0]                       row;
  } render_req_t;

  function automatic logic [GLYPH_CODE_W-1:0] glyph_code(input logic [7:0] ascii);
    logic [GLYPH_CODE_W-1:0] code;
    code = GLYPH_BLANK;
    if (ascii >= ASCII_A && ascii <= ASCII_Z) begin
      code = GLYPH_CODE_W'(ascii - ASCII_A + 8'd1);
    end else if (ascii == ASCII_BANG) begin
      code = GLYPH_BANG;
    end
    return code;
  endfunction

  // The font is seven rows tall, so the bottom panel row is always blank.
  function automatic logic [GLYPH_WIDTH-1:0] glyph_row(input logic [GLYPH_CODE_W-1:0] code,
                                                       input logic [ROW_W-1:0] row);
    logic [GLYPH_WIDTH-1:0] bits;
    bits = '0;
    if (row < ROW_W'(FONT_ROWS)) begin
      bits = FONT_ROM[code][row];
    end
    return bits;
  endfunction

endpackage

>>> hdl/stwr_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module stwr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/stwr_raster.sv
// Row rasterizer: turns the fetched glyph codes of a frame into 32 panel pixels.
// Depends on stwr_pkg for the font ROM and the render request type.
module stwr_raster import stwr_pkg::*; (
  input  render_req_t              req,
  output logic [PANEL_WIDTH-1:0]   row_bits
);

  logic [STRIP_W-1:0] strip;
  logic [STRIP_W-1:0] shifted;

  // Slot zero lands leftmost in the strip; the offset drops its leading columns.
  always_comb begin
    strip = '0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      strip[STRIP_W-1-k*GLYPH_WIDTH -: GLYPH_WIDTH] = glyph_row(req.codes[k], req.row);
    end
    shifted = strip << req.offset;
  end

  assign row_bits = shifted[STRIP_W-1 -: PANEL_WIDTH];

endmodule

>>> hdl/stwr_ctrl.sv
// Sequencer of the renderer: input handshake, text store access, glyph fetch and
// the output register. Depends on stwr_pkg and assert_macros.svh.
`include "assert_macros.svh"
module stwr_ctrl import stwr_pkg::*; #(
  parameter int MAX_CHARS = DEF_MAX_CHARS,
  localparam int AW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [LEN_W-1:0]        cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_kind,
  input  logic [5:0]              in_char_index,
  input  logic [7:0]              in_char_code,
  input  logic signed [POS_W-1:0] in_scroll_position,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ROW_W-1:0]        out_row_index,
  output logic [PANEL_WIDTH-1:0]  out_row_bits,
  output logic                    out_last_row,
  output logic                    ram_we,
  output logic [AW-1:0]           ram_waddr,
  output logic [GLYPH_CODE_W-1:0] ram_wdata,
  output logic                    ram_re,
  output logic [AW-1:0]           ram_raddr,
  input  logic [GLYPH_CODE_W-1:0] ram_rdata,
  output render_req_t             req,
  input  logic [PANEL_WIDTH-1:0]  row_bits
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DIV    = 4'b0010,
    ST_FETCH  = 4'b0100,
    ST_RENDER = 4'b1000
  } state_t;

  localparam logic [8:0] MAX_LEN = 9'(MAX_CHARS);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_SLOTS - 1);

  state_t state_r, state_nxt;

  logic [LEN_W-1:0]  len_r;
  logic [8:0]        len_eff;
  logic [POS_W-1:0]  q_r;
  logic              blank_r;
  logic [6:0]        b_r;
  logic [OFF_W-1:0]  off_r;
  logic [SLOT_W-1:0] k_r;
  logic [SLOT_W-1:0] rd_slot_r;
  logic              rd_ok_r;
  logic              rd_pend_r;
  logic [ROW_W-1:0]  row_r;
  logic [NUM_SLOTS-1:0][GLYPH_CODE_W-1:0] codes_r;

  logic                   out_valid_r;
  logic [ROW_W-1:0]       out_row_r;
  logic [PANEL_WIDTH-1:0] out_bits_r;
  logic                   out_last_r;

  logic        accept;
  logic        load;
  logic [10:0] biased;
  logic [19:0] prod;
  logic [9:0]  six_b;
  logic [7:0]  slot_idx;
  logic        slot_ok;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Bias the position by six glyphs; anything still negative shows no column.
  assign biased  = {in_scroll_position[POS_W-1], in_scroll_position} + 11'(BIAS_COLS);
  assign prod    = 20'(q_r) * 20'(RECIP6);
  assign six_b   = ({3'b000, b_r} << 2) + ({3'b000, b_r} << 1);
  assign len_eff = ({2'b00, len_r} > MAX_LEN) ? MAX_LEN : {2'b00, len_r};

  // Slot k holds message character b - 6 + k; it is blank outside the message.
  assign slot_idx = {1'b0, b_r} + {5'b00000, k_r};
  assign slot_ok  = !blank_r && (slot_idx >= 8'(BIAS_SLOTS))
                    && (({1'b0, slot_idx} - 9'(BIAS_SLOTS)) < len_eff);

  assign ram_we    = accept && (in_kind == KIND_WRITE) && ({3'b000, in_char_index} < MAX_LEN);
  assign ram_waddr = AW'(in_char_index);
  assign ram_wdata = glyph_code(in_char_code);
  assign ram_re    = (state_r == ST_FETCH) && slot_ok;
  assign ram_raddr = AW'(slot_idx - 8'(BIAS_SLOTS));

  assign req.codes  = codes_r;
  assign req.offset = off_r;
  assign req.row    = row_r;

  always_comb begin
    state_nxt = state_r;
    load      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_kind == KIND_FRAME) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        if (k_r == SLOT_LAST) state_nxt = ST_RENDER;
      end
      ST_RENDER: begin
        // The last glyph read lands in the cycle after the fetch state ends.
        load = !rd_pend_r && (!out_valid_r || out_ready);
        if (load && row_r == LAST_ROW) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
      len_r       <= '0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= (state_r == ST_FETCH);
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        len_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_r     <= biased[POS_W-1:0];
      blank_r <= biased[10];
    end
    if (state_r == ST_DIV) begin
      b_r   <= prod[RECIP6_SHIFT +: 7];
      k_r   <= '0;
      row_r <= '0;
    end
    if (state_r == ST_FETCH) begin
      k_r       <= k_r + 1'b1;
      rd_slot_r <= k_r;
      rd_ok_r   <= slot_ok;
      off_r     <= OFF_W'(q_r - six_b);
    end
    if (rd_pend_r) begin
      codes_r[rd_slot_r] <= rd_ok_r ? ram_rdata : GLYPH_BLANK;
    end
    if (load) begin
      row_r      <= row_r + 1'b1;
      out_row_r  <= row_r;
      out_bits_r <= row_bits;
      out_last_r <= (row_r == LAST_ROW);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row_index = out_row_r;
  assign out_row_bits  = out_bits_r;
  assign out_last_row  = out_last_r;

  `ASSERT_IMPLIES(a_busy_no_accept, state_r != ST_IDLE, !in_ready, "item accepted while busy")
  `ASSERT_IMPLIES(a_bottom_blank, out_valid_r && out_row_r == LAST_ROW, out_bits_r == '0,
                  "bottom panel row is not blank")
  `ASSERT_IMPLIES(a_fetch_range, state_r == ST_FETCH, k_r <= SLOT_LAST, "fetch slot overrun")
  `ASSERT_NEXT(a_last_to_idle, load && row_r == LAST_ROW, state_r == ST_IDLE && out_last_r,
               "frame did not end after its last row")

endmodule

>>> hdl/scrolling_text_window_renderer_core.sv
// Top level of the scrolling text renderer for an 8 by 32 LED panel.
// Depends on stwr_pkg, stwr_ram, stwr_ctrl and stwr_raster.
//
// Usage:
//   Input channel (in_valid / in_ready): in_kind 0 stores in_char_code, mapped
//   to a glyph, at in_char_index (indexes at or above MAX_CHARS are dropped);
//   in_kind 1 renders a frame at the signed in_scroll_position.
//   Result channel (out_valid / out_ready): a frame returns eight rows, top row
//   first, bit 31 leftmost; out_last_row marks the eighth row.
//   Configuration: cfg_we writes cfg_wdata into the message length; write it
//   only while no frame is in progress.
// Timing: a character write is stored in the cycle it is accepted. A frame
//   passes from acceptance through the divide by six, a walk over the seven
//   glyph slots that reads the text memory for those inside the message (one
//   port, one glyph a cycle), the wait for the last read data, then one row a
//   cycle while the receiver does not stall. The next item is accepted as soon
//   as the last row sits in the output register.
// A stalled receiver holds the current row and pauses rendering. Reset clears
//   the message length and the control state; the text memory is not cleared,
//   so every character shown must be written first.
module scrolling_text_window_renderer_core import stwr_pkg::*; #(
  parameter int MAX_CHARS = DEF_MAX_CHARS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [LEN_W-1:0]        cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_kind,
  input  logic [5:0]              in_char_index,
  input  logic [7:0]              in_char_code,
  input  logic signed [POS_W-1:0] in_scroll_position,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ROW_W-1:0]        out_row_index,
  output logic [PANEL_WIDTH-1:0]  out_row_bits,
  output logic                    out_last_row
);

  localparam int AW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [GLYPH_CODE_W-1:0] ram_wdata;
  logic                    ram_re;
  logic [AW-1:0]           ram_raddr;
  logic [GLYPH_CODE_W-1:0] ram_rdata;
  render_req_t             req;
  logic [PANEL_WIDTH-1:0]  row_bits;

  stwr_ram #(
    .WIDTH (GLYPH_CODE_W),
    .DEPTH (MAX_CHARS)
  ) u_text_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  stwr_ctrl #(
    .MAX_CHARS (MAX_CHARS)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_char_index      (in_char_index),
    .in_char_code       (in_char_code),
    .in_scroll_position (in_scroll_position),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_row_index      (out_row_index),
    .out_row_bits       (out_row_bits),
    .out_last_row       (out_last_row),
    .ram_we             (ram_we),
    .ram_waddr          (ram_waddr),
    .ram_wdata          (ram_wdata),
    .ram_re             (ram_re),
    .ram_raddr          (ram_raddr),
    .ram_rdata          (ram_rdata),
    .req                (req),
    .row_bits           (row_bits)
  );

  stwr_raster u_raster (
    .req      (req),
    .row_bits (row_bits)
  );

endmodule

>>> tb/tb.sv
// Testbench for scrolling_text_window_renderer_core: character writes, frame
// requests and message length settings, with every panel row checked against
// a local pixel predictor. Depends on stwr_pkg and the core RTL only.
module tb import stwr_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH  = 64;
  localparam int GLYPH_COLS   = 6;
  localparam int FRAME_ROWS   = 8;
  localparam int GLYPH_ROWS   = 7;
  localparam int SETTLE_CYCLES = 24;
  localparam int LONG_HOLD    = 200;
  localparam int CYCLE_LIMIT  = 300000;

  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [4:0] GL_BLANK = 5'd0;
  localparam logic [4:0] GL_BANG  = 5'd27;

  // Glyph rows, bit 5 is the leftmost pixel; code 0 is blank, 1..26 letters, 27 '!'.
  localparam logic [5:0] TB_FONT [0:27][0:6] = '{
    '{6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00},
    '{6'h08, 6'h14, 6'h22, 6'h3E, 6'h22, 6'h22, 6'h22},
    '{6'h3C, 6'h22, 6'h22, 6'h3C, 6'h22, 6'h22, 6'h3C},
    '{6'h1C, 6'h22, 6'h20, 6'h20, 6'h20, 6'h22, 6'h1C},
    '{6'h3C, 6'h22, 6'h22, 6'h22, 6'h22, 6'h22, 6'h3C},
    '{6'h3E, 6'h20, 6'h20, 6'h3C, 6'h20, 6'h20, 6'h3E},
    '{6'h3E, 6'h20, 6'h20, 6'h3C, 6'h20, 6'h20, 6'h20},
    '{6'h1C, 6'h22, 6'h20, 6'h26, 6'h22, 6'h22, 6'h1E},
    '{6'h22, 6'h22, 6'h22, 6'h3E, 6'h22, 6'h22, 6'h22},
    '{6'h1C, 6'h08, 6'h08, 6'h08, 6'h08, 6'h08, 6'h1C},
    '{6'h0E, 6'h04, 6'h04, 6'h04, 6'h04, 6'h24, 6'h18},
    '{6'h22, 6'h24, 6'h28, 6'h30, 6'h28, 6'h24, 6'h22},
    '{6'h20, 6'h20, 6'h20, 6'h20, 6'h20, 6'h20, 6'h3E},
    '{6'h22, 6'h36, 6'h2A, 6'h22, 6'h22, 6'h22, 6'h22},
    '{6'h22, 6'h32, 6'h2A, 6'h26, 6'h22, 6'h22, 6'h22},
    '{6'h1C, 6'h22, 6'h22, 6'h22, 6'h22, 6'h22, 6'h1C},
    '{6'h3C, 6'h22, 6'h22, 6'h3C, 6'h20, 6'h20, 6'h20},
    '{6'h1C, 6'h22, 6'h22, 6'h22, 6'h2A, 6'h24, 6'h1A},
    '{6'h3C, 6'h22, 6'h22, 6'h3C, 6'h28, 6'h24, 6'h22},
    '{6'h1C, 6'h22, 6'h20, 6'h1C, 6'h02, 6'h22, 6'h1C},
    '{6'h3E, 6'h08, 6'h08, 6'h08, 6'h08, 6'h08, 6'h08},
    '{6'h22, 6'h22, 6'h22, 6'h22, 6'h22, 6'h22, 6'h1C},
    '{6'h22, 6'h22, 6'h22, 6'h22, 6'h22, 6'h14, 6'h08},
    '{6'h22, 6'h22, 6'h22, 6'h22, 6'h2A, 6'h2A, 6'h14},
    '{6'h22, 6'h22, 6'h14, 6'h08, 6'h14, 6'h22, 6'h22},
    '{6'h22, 6'h22, 6'h22, 6'h14, 6'h08, 6'h08, 6'h08},
    '{6'h3E, 6'h02, 6'h04, 6'h08, 6'h10, 6'h20, 6'h3E},
    '{6'h08, 6'h08, 6'h08, 6'h08, 6'h08, 6'h00, 6'h08}
  };

  typedef struct {
    logic              kind;
    logic [5:0]        idx;
    logic [7:0]        code;
    logic signed [9:0] pos;
    bit                drain;
  } panel_item_t;

  typedef struct packed {
    logic [2:0]  row;
    logic [31:0] bits;
    logic        last;
  } panel_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [LEN_W-1:0]        cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    in_kind = 1'b0;
  logic [5:0]              in_char_index = '0;
  logic [7:0]              in_char_code = '0;
  logic signed [POS_W-1:0] in_scroll_position = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [ROW_W-1:0]        out_row_index;
  logic [PANEL_WIDTH-1:0]  out_row_bits;
  logic                    out_last_row;

  panel_item_t pending_items[$];
  panel_row_t  row_expect[$];
  panel_item_t drv_item;
  panel_row_t  want_row;

  logic [4:0] model_glyph [0:STORE_DEPTH-1];
  logic [6:0] model_len;
  bit         gen_written [0:STORE_DEPTH-1];
  int         gen_len = 0;

  bit in_fire = 1'b0;
  bit long_hold_go = 1'b0;
  bit long_hold_seen = 1'b0;
  int hold_left = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int n_queued = 0;
  int n_accepted = 0;
  int n_errors = 0;
  int n_writes = 0;
  int n_frames = 0;
  int n_rows = 0;
  int cycle_count = 0;

  scrolling_text_window_renderer_core u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_char_index      (in_char_index),
    .in_char_code       (in_char_code),
    .in_scroll_position (in_scroll_position),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_row_index      (out_row_index),
    .out_row_bits       (out_row_bits),
    .out_last_row       (out_last_row)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic logic [4:0] to_glyph(input logic [7:0] ascii);
    if (ascii >= CH_A && ascii <= CH_Z) return 5'(ascii - CH_A + 1);
    if (ascii == CH_BANG) return GL_BANG;
    return GL_BLANK;
  endfunction

  // Panel column c shows message pixel column c + pos; outside the strip it is dark.
  function automatic logic [31:0] panel_row_bits(input int row, input int pos);
    int strip, m;
    logic [31:0] bits;
    logic [5:0] pattern;
    strip = ((int'(model_len) > STORE_DEPTH) ? STORE_DEPTH : int'(model_len)) * GLYPH_COLS;
    bits = '0;
    if (row < GLYPH_ROWS) begin
      for (int c = 0; c < 32; c++) begin
        m = c + pos;
        if (m >= 0 && m < strip) begin
          pattern = TB_FONT[model_glyph[m / GLYPH_COLS]][row];
          if (pattern[GLYPH_COLS - 1 - (m % GLYPH_COLS)]) bits[31 - c] = 1'b1;
        end
      end
    end
    return bits;
  endfunction

  // Sender: a new item goes out only once the previous one has been taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= tx_idle_pct &&
          (!pending_items[0].drain || row_expect.size() == 0)) begin
        drv_item = pending_items.pop_front();
        in_valid <= 1'b1;
        in_kind <= drv_item.kind;
        in_char_index <= drv_item.idx;
        in_char_code <= drv_item.code;
        in_scroll_position <= drv_item.pos;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold requested by the stimulus.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (long_hold_go && !long_hold_seen) begin
      long_hold_seen <= 1'b1;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire <= 1'b0;
      model_len = '0;
      for (int i = 0; i < STORE_DEPTH; i++) model_glyph[i] = GL_BLANK;
    end else begin
      in_fire <= in_valid && in_ready;
      if (cfg_we) model_len = cfg_wdata;
      if (in_valid && in_ready) begin
        n_accepted++;
        if (in_kind == KIND_WRITE) begin
          model_glyph[in_char_index] = to_glyph(in_char_code);
          n_writes++;
        end else begin
          for (int r = 0; r < FRAME_ROWS; r++) begin
            row_expect.push_back('{3'(r), panel_row_bits(r, int'(in_scroll_position)),
                                   r == FRAME_ROWS - 1});
          end
          n_frames++;
        end
      end
      if (out_valid && out_ready) begin
        n_rows++;
        if (row_expect.size() == 0) begin
          $error("unexpected row: row_index %0d row_bits %h", out_row_index, out_row_bits);
          n_errors++;
        end else begin
          want_row = row_expect.pop_front();
          if (out_row_index !== want_row.row) begin
            $error("row_index: expected %0d, got %0d", want_row.row, out_row_index);
            n_errors++;
          end
          if (out_row_bits !== want_row.bits) begin
            $error("row_bits: expected %h, got %h", want_row.bits, out_row_bits);
            n_errors++;
          end
          if (out_last_row !== want_row.last) begin
            $error("last_row: expected %0d, got %0d", want_row.last, out_last_row);
            n_errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out with %0d rows still expected.", row_expect.size());
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int pick_code();
    case ($urandom_range(9))
      0, 1: return $urandom_range(255);
      2: return CH_SPACE;
      3: return CH_BANG;
      default: return CH_A + $urandom_range(25);
    endcase
  endfunction

  function automatic int shown_chars();
    return (gen_len > STORE_DEPTH) ? STORE_DEPTH : gen_len;
  endfunction

  task automatic push_item(input logic kind, input int idx, input int code, input int pos,
                           input bit drain);
    pending_items.push_back('{kind, 6'(idx), 8'(code), 10'(pos), drain});
    n_queued++;
  endtask

  task automatic put_char(input int idx, input int code);
    push_item(KIND_WRITE, idx, code, int'($urandom_range(1023)) - 512, 1'b0);
    gen_written[idx] = 1'b1;
  endtask

  // Any character that the frame would show must have been written first.
  task automatic show_frame(input int pos, input bit drain);
    int lo, hi;
    lo = (pos < 0) ? 0 : pos;
    hi = pos + 31;
    if (hi > shown_chars() * GLYPH_COLS - 1) hi = shown_chars() * GLYPH_COLS - 1;
    for (int m = lo; m <= hi; m++) begin
      if (!gen_written[m / GLYPH_COLS]) put_char(m / GLYPH_COLS, pick_code());
    end
    push_item(KIND_FRAME, $urandom_range(63), $urandom_range(255), pos, drain);
  endtask

  task automatic wait_idle();
    wait (n_accepted == n_queued && row_expect.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input int len);
    wait_idle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= LEN_W'(len);
    gen_len = len;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(input int count, input int tx_pct, input int rx_pct);
    int done, sel, p, steps, step_sz, eff;
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    done = 0;
    while (done < count) begin
      eff = shown_chars();
      sel = $urandom_range(99);
      p = int'($urandom_range(eff * GLYPH_COLS + 32)) - 32;
      if (sel < 15) begin
        // A short scroll across the message, as a panel refresh would do.
        steps = 3 + $urandom_range(3);
        step_sz = 1 + $urandom_range(2);
        for (int k = 0; k < steps; k++) show_frame(p + k * step_sz, 1'b0);
        done += steps;
      end else if (sel < 55) begin
        show_frame(p, $urandom_range(19) == 0);
        done++;
      end else if (sel < 62) begin
        show_frame(int'($urandom_range(1023)) - 512, 1'b0);
        done++;
      end else begin
        if (eff > 0 && $urandom_range(3) != 0) put_char($urandom_range(eff - 1), pick_code());
        else put_char($urandom_range(STORE_DEPTH - 1), pick_code());
        done++;
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty message, then the extremes of the scroll position, then character writes.
    write_length(0);
    show_frame(0, 1'b0);
    show_frame(-512, 1'b0);
    show_frame(511, 1'b0);
    put_char(0, CH_A);
    put_char(1, CH_Z);
    put_char(2, CH_BANG);
    put_char(3, CH_SPACE);
    put_char(4, 8'h00);
    put_char(5, 8'hFF);
    put_char(6, CH_A + 12);
    put_char(63, CH_A + 16);

    // Seven characters: left padding, edges of the strip and positions past it.
    write_length(7);
    show_frame(-32, 1'b0);
    show_frame(-31, 1'b0);
    show_frame(-6, 1'b0);
    show_frame(0, 1'b0);
    show_frame(3, 1'b0);
    show_frame(17, 1'b0);
    show_frame(41, 1'b0);
    show_frame(42, 1'b0);
    wait_idle();

    // The receiver holds off for a long time while frames keep coming; the last
    // frame waits until every row before it has come out.
    long_hold_go = 1'b1;
    for (int k = 0; k < 6; k++) show_frame(int'($urandom_range(73)) - 32, k == 5);

    write_length(64);
    run_random(20, 0, 0);
    write_length(1);
    run_random(18, 75, 0);
    write_length(127);
    run_random(18, 0, 75);
    write_length(2 + $urandom_range(61));
    run_random(18, 21, 21);

    wait (n_accepted == n_queued && row_expect.size() == 0);
    repeat (40) @(posedge clk);
    $display("Checked %0d rows from %0d frames after %0d character writes,",
             n_rows, n_frames, n_writes);
    $display("across message lengths 0 to 127, stalls on both sides and one long hold.");
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/stwr_pkg.sv
hdl/stwr_ram.sv
hdl/stwr_raster.sv
hdl/stwr_ctrl.sv
hdl/scrolling_text_window_renderer_core.sv
tb/tb.sv
